// File: sv/hdc_pkg.sv
// Shared types, register indexes and slot decode for the halo classifier.
// No dependencies; used by hdc_cfg, hdc_alu and atom_domain_halo_classifier.
package hdc_pkg;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_GRID_DIMS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OWN_COORDS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN_X   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN_Y   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN_Z   = 3'd4;

    localparam int NUM_SLOTS = 27;
    localparam int SLOT_W    = 5;
    localparam logic [SLOT_W-1:0] CENTER_SLOT = 5'd13;

    localparam logic [1:0] DIG_NEG = 2'd0;
    localparam logic [1:0] DIG_MID = 2'd1;
    localparam logic [1:0] DIG_POS = 2'd2;

    localparam logic [2:0] DIR_LOCAL  = 3'd6;
    localparam logic       KIND_OWNER = 1'b0;
    localparam logic       KIND_GHOST = 1'b1;

    typedef struct packed {
        logic ge_lo;
        logic lt_hi;
    } slab_flags_t;

    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
        logic [1:0] dz;
    } slot_dig_t;

    // slot = 9*dx + 3*dy + dz, digits 0..2 for offsets -1..1
    function automatic slot_dig_t slot_digits(input logic [SLOT_W-1:0] slot);
        slot_dig_t r;
        r = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot == SLOT_W'(i))
            begin
                r.dx = 2'(i / 9);
                r.dy = 2'((i / 3) % 3);
                r.dz = 2'(i % 3);
            end
        end
        return r;
    endfunction

    function automatic logic signed [1:0] dig_offset(input logic [1:0] dig);
        logic signed [1:0] r;
        case (dig)
            DIG_NEG: r = 2'sb11;
            DIG_MID: r = 2'sb00;
            DIG_POS: r = 2'sb01;
            default: r = 2'sb00;
        endcase
        return r;
    endfunction

endpackage

// File: sv/atom_domain_halo_classifier.sv
// Top level: sequencer around the shared hdc_alu, config file and result registers.
// Depends on hdc_pkg, hdc_cfg, hdc_alu.
//
//  channel   handshake                 payload
//  config    cfg_we                    cfg_index, cfg_data
//  input     start && !busy            frac_x, frac_y, frac_z
//  result    result_strobe (1 cycle)   kind, owner_id, migrate_dir, target_rank,
//                                      offset_x/y/z, shift_x/y/z, layer_overflow, last
//
// Per axis the shared multiplier and slab compare run four steps; after all three axes
// the atom's ownership beat is presented, followed back to back by its ghost beats (0 to 26).
// A new atom is accepted only once busy has dropped after the previous atom's final beat.
// busy is high from acceptance until the edge that presents the final beat.
// Reset clears all registers: one domain per axis, zero margins.
// Results cannot be stalled; each beat is valid for exactly one cycle.
module atom_domain_halo_classifier #(
    parameter int FRAC_BITS = 24,
    parameter int DIM_BITS  = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hdc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [((3*DIM_BITS > FRAC_BITS+2) ? 3*DIM_BITS : FRAC_BITS+2)-1:0] cfg_data,
    input  logic                          start,
    input  logic [FRAC_BITS-1:0]          frac_x,
    input  logic [FRAC_BITS-1:0]          frac_y,
    input  logic [FRAC_BITS-1:0]          frac_z,
    output logic                          busy,
    output logic                          result_strobe,
    output logic                          kind,
    output logic [3*DIM_BITS-1:0]         owner_id,
    output logic [2:0]                    migrate_dir,
    output logic [3*DIM_BITS-1:0]         target_rank,
    output logic signed [1:0]             offset_x,
    output logic signed [1:0]             offset_y,
    output logic signed [1:0]             offset_z,
    output logic signed [1:0]             shift_x,
    output logic signed [1:0]             shift_y,
    output logic signed [1:0]             shift_z,
    output logic                          layer_overflow,
    output logic                          last
);

    localparam int CFG_W = (3*DIM_BITS > FRAC_BITS+2) ? 3*DIM_BITS : FRAC_BITS+2;
    localparam int DW    = DIM_BITS;
    localparam int RW    = 3 * DIM_BITS;
    localparam int WW    = 2 * DIM_BITS + 1;
    localparam int AW    = FRAC_BITS + 2;
    localparam int PW    = FRAC_BITS + DIM_BITS + 1;
    localparam int MW    = FRAC_BITS + DIM_BITS + 3;
    localparam int NS    = hdc_pkg::NUM_SLOTS;
    localparam int SW    = hdc_pkg::SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MF,
        ST_MM,
        ST_CL,
        ST_CH,
        ST_OWN,
        ST_GHOST
    } state_t;

    state_t            state_reg;
    logic [1:0]        ax_reg;
    logic [FRAC_BITS-1:0] f_reg [3];
    logic [WW-1:0]     dd_reg;
    logic [PW-1:0]     p_reg;
    logic [MW-1:0]     md_reg;
    logic [DW-1:0]     o_reg;
    logic [RW-1:0]     own_acc_reg;
    logic              ovf_reg;
    logic              ok_reg    [3][3];
    logic [RW-1:0]     rterm_reg [3][3];
    logic signed [1:0] shf_reg   [3][3];
    logic              dnz_reg   [3];
    logic              dpos_reg  [3];
    logic [NS-1:0]     pending_reg;

    logic              strobe_reg;
    logic              kind_reg;
    logic [RW-1:0]     owner_reg;
    logic [2:0]        dir_reg;
    logic [RW-1:0]     target_reg;
    logic signed [1:0] off_reg [3];
    logic signed [1:0] sh_reg  [3];
    logic              ovf_out_reg;
    logic              last_reg;

    logic [DW:0]          dim    [3];
    logic [DW-1:0]        own    [3];
    logic [FRAC_BITS+1:0] margin [3];

    logic [AW-1:0]     mul_a;
    logic [DW:0]       mul_b;
    logic [MW-1:0]     prod;
    logic [DW-1:0]     slab_t;
    logic signed [1:0] slab_s;
    hdc_pkg::slab_flags_t flags;

    logic [DW:0]       d_ax;
    logic [DW-1:0]     c_ax;
    logic [DW-1:0]     dm1;
    logic [DW-1:0]     tm;
    logic [DW-1:0]     tp;
    logic signed [1:0] sm;
    logic signed [1:0] sp;
    logic [WW-1:0]     w;
    logic [DW:0]       o_raw;
    logic [DW-1:0]     o_clamp;
    logic signed [DW+1:0] delta;
    logic signed [DW+1:0] half;
    logic signed [DW+1:0] dsd;
    logic              md_over;
    logic [NS-1:0]     mask;
    logic [SW-1:0]     sel_slot;
    hdc_pkg::slot_dig_t sel_dig;
    logic [NS-1:0]     pend_clr;
    logic              ghost_last;
    logic [2:0]        own_dir;

    hdc_cfg #(
        .FRAC_BITS (FRAC_BITS),
        .DIM_BITS  (DIM_BITS),
        .CFG_W     (CFG_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dim       (dim),
        .own       (own),
        .margin    (margin)
    );

    hdc_alu #(
        .FRAC_BITS (FRAC_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_alu (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod),
        .p     (p_reg),
        .md    (md_reg),
        .d     (d_ax),
        .t     (slab_t),
        .s     (slab_s),
        .flags (flags)
    );

    assign d_ax    = dim[ax_reg];
    assign c_ax    = own[ax_reg];
    assign dm1     = DW'(d_ax - 1'b1);
    assign tm      = (c_ax == '0) ? dm1 : c_ax - 1'b1;
    assign tp      = (c_ax == dm1) ? '0 : c_ax + 1'b1;
    assign sm      = (c_ax == '0) ? 2'sb01 : 2'sb00;
    assign sp      = (c_ax == dm1) ? 2'sb11 : 2'sb00;
    assign slab_t  = (state_reg == ST_CL) ? tm : tp;
    assign slab_s  = (state_reg == ST_CL) ? sm : sp;
    assign o_raw   = p_reg[FRAC_BITS +: DW+1];
    assign o_clamp = (o_raw > {1'b0, dm1}) ? dm1 : DW'(o_raw);
    assign md_over = (md_reg > (MW'(1) << FRAC_BITS));

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = AW'(dim[1]);
                mul_b = dim[2];
            end
            ST_MF:
            begin
                mul_a = AW'(f_reg[ax_reg]);
                mul_b = d_ax;
            end
            ST_MM:
            begin
                mul_a = margin[ax_reg];
                mul_b = d_ax;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rank weight of this axis: Dy*Dz, Dz, 1
    always_comb
    begin
        case (ax_reg)
            2'd0:    w = dd_reg;
            2'd1:    w = WW'(dim[2]);
            default: w = WW'(1);
        endcase
    end

    // minimum-image grid distance of owner vs. this domain
    always_comb
    begin
        half  = $signed({1'b0, d_ax >> 1});
        dsd   = $signed({1'b0, d_ax});
        delta = $signed({2'b00, o_reg}) - $signed({2'b00, c_ax});
        if (delta > half)
            delta = delta - dsd;
        if (delta < -half)
            delta = delta + dsd;
    end

    always_comb
    begin
        if (dnz_reg[0])
            own_dir = {2'd0, dpos_reg[0]};
        else if (dnz_reg[1])
            own_dir = {2'd1, dpos_reg[1]};
        else if (dnz_reg[2])
            own_dir = {2'd2, dpos_reg[2]};
        else
            own_dir = hdc_pkg::DIR_LOCAL;
    end

    always_comb
    begin
        hdc_pkg::slot_dig_t sd;
        mask = '0;
        for (int j = 0; j < NS; j++)
        begin
            sd      = hdc_pkg::slot_digits(SW'(j));
            mask[j] = (SW'(j) != hdc_pkg::CENTER_SLOT) && ok_reg[0][sd.dx]
                      && ok_reg[1][sd.dy] && ok_reg[2][sd.dz];
        end
    end

    always_comb
    begin
        sel_slot = '0;
        for (int j = NS - 1; j >= 0; j--)
        begin
            if (pending_reg[j])
                sel_slot = SW'(j);
        end
    end

    assign sel_dig    = hdc_pkg::slot_digits(sel_slot);
    assign pend_clr   = pending_reg & ~(NS'(1) << sel_slot);
    assign ghost_last = (pend_clr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ax_reg      <= '0;
            f_reg       <= '{default: '0};
            dd_reg      <= '0;
            p_reg       <= '0;
            md_reg      <= '0;
            o_reg       <= '0;
            own_acc_reg <= '0;
            ovf_reg     <= 1'b0;
            ok_reg      <= '{default: '{default: 1'b0}};
            rterm_reg   <= '{default: '{default: '0}};
            shf_reg     <= '{default: '{default: 2'sb00}};
            dnz_reg     <= '{default: 1'b0};
            dpos_reg    <= '{default: 1'b0};
            pending_reg <= '0;
            strobe_reg  <= 1'b0;
            kind_reg    <= hdc_pkg::KIND_OWNER;
            owner_reg   <= '0;
            dir_reg     <= '0;
            target_reg  <= '0;
            off_reg     <= '{default: 2'sb00};
            sh_reg      <= '{default: 2'sb00};
            ovf_out_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        f_reg[0]    <= frac_x;
                        f_reg[1]    <= frac_y;
                        f_reg[2]    <= frac_z;
                        dd_reg      <= prod[WW-1:0];
                        ovf_reg     <= 1'b0;
                        own_acc_reg <= '0;
                        ax_reg      <= '0;
                        state_reg   <= ST_MF;
                    end
                end
                ST_MF:
                begin
                    p_reg     <= prod[PW-1:0];
                    state_reg <= ST_MM;
                end
                ST_MM:
                begin
                    md_reg    <= prod;
                    o_reg     <= o_clamp;
                    state_reg <= ST_CL;
                end
                ST_CL:
                begin
                    ok_reg[ax_reg][hdc_pkg::DIG_NEG]    <= flags.ge_lo & flags.lt_hi;
                    ok_reg[ax_reg][hdc_pkg::DIG_MID]    <= 1'b1;
                    shf_reg[ax_reg][hdc_pkg::DIG_NEG]   <= sm;
                    shf_reg[ax_reg][hdc_pkg::DIG_MID]   <= 2'sb00;
                    rterm_reg[ax_reg][hdc_pkg::DIG_NEG] <= RW'(tm) * RW'(w);
                    own_acc_reg <= own_acc_reg + RW'(o_reg) * RW'(w);
                    ovf_reg     <= ovf_reg | md_over;
                    dnz_reg[ax_reg]  <= (delta != '0);
                    dpos_reg[ax_reg] <= (delta > 0);
                    state_reg   <= ST_CH;
                end
                ST_CH:
                begin
                    ok_reg[ax_reg][hdc_pkg::DIG_POS]    <= flags.ge_lo & flags.lt_hi;
                    shf_reg[ax_reg][hdc_pkg::DIG_POS]   <= sp;
                    rterm_reg[ax_reg][hdc_pkg::DIG_MID] <= RW'(c_ax) * RW'(w);
                    rterm_reg[ax_reg][hdc_pkg::DIG_POS] <= RW'(tp) * RW'(w);
                    if (ax_reg == 2'd2)
                        state_reg <= ST_OWN;
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= ST_MF;
                    end
                end
                ST_OWN:
                begin
                    strobe_reg  <= 1'b1;
                    kind_reg    <= hdc_pkg::KIND_OWNER;
                    owner_reg   <= own_acc_reg;
                    dir_reg     <= own_dir;
                    target_reg  <= '0;
                    off_reg     <= '{default: 2'sb00};
                    sh_reg      <= '{default: 2'sb00};
                    ovf_out_reg <= ovf_reg;
                    last_reg    <= (mask == '0);
                    pending_reg <= mask;
                    state_reg   <= (mask == '0) ? ST_IDLE : ST_GHOST;
                end
                ST_GHOST:
                begin
                    strobe_reg  <= 1'b1;
                    kind_reg    <= hdc_pkg::KIND_GHOST;
                    dir_reg     <= '0;
                    target_reg  <= rterm_reg[0][sel_dig.dx] + rterm_reg[1][sel_dig.dy]
                                   + rterm_reg[2][sel_dig.dz];
                    off_reg[0]  <= hdc_pkg::dig_offset(sel_dig.dx);
                    off_reg[1]  <= hdc_pkg::dig_offset(sel_dig.dy);
                    off_reg[2]  <= hdc_pkg::dig_offset(sel_dig.dz);
                    sh_reg[0]   <= shf_reg[0][sel_dig.dx];
                    sh_reg[1]   <= shf_reg[1][sel_dig.dy];
                    sh_reg[2]   <= shf_reg[2][sel_dig.dz];
                    last_reg    <= ghost_last;
                    pending_reg <= pend_clr;
                    if (ghost_last)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_strobe  = strobe_reg;
    assign kind           = kind_reg;
    assign owner_id       = owner_reg;
    assign migrate_dir    = dir_reg;
    assign target_rank    = target_reg;
    assign offset_x       = off_reg[0];
    assign offset_y       = off_reg[1];
    assign offset_z       = off_reg[2];
    assign shift_x        = sh_reg[0];
    assign shift_y        = sh_reg[1];
    assign shift_z        = sh_reg[2];
    assign layer_overflow = ovf_out_reg;
    assign last           = last_reg;

endmodule

// File: sv/hdc_cfg.sv
// Configuration register file: grid size, own coordinate and halo margins.
// Depends on hdc_pkg (register indexes).
module hdc_cfg #(
    parameter int FRAC_BITS = 24,
    parameter int DIM_BITS  = 4,
    parameter int CFG_W     = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hdc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    output logic [DIM_BITS:0]             dim [3],
    output logic [DIM_BITS-1:0]           own [3],
    output logic [FRAC_BITS+1:0]          margin [3]
);

    localparam int RW = 3 * DIM_BITS;

    logic [RW-1:0]        grid_reg;
    logic [RW-1:0]        own_reg;
    logic [FRAC_BITS+1:0] margin_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg      <= '0;
            own_reg       <= '0;
            margin_reg[0] <= '0;
            margin_reg[1] <= '0;
            margin_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hdc_pkg::REG_GRID_DIMS:  grid_reg      <= cfg_data[RW-1:0];
                hdc_pkg::REG_OWN_COORDS: own_reg       <= cfg_data[RW-1:0];
                hdc_pkg::REG_MARGIN_X:   margin_reg[0] <= cfg_data[FRAC_BITS+1:0];
                hdc_pkg::REG_MARGIN_Y:   margin_reg[1] <= cfg_data[FRAC_BITS+1:0];
                hdc_pkg::REG_MARGIN_Z:   margin_reg[2] <= cfg_data[FRAC_BITS+1:0];
                default: ;
            endcase
        end
    end

    // x in the high field; own coordinate saturates at dim-1
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic [DIM_BITS-1:0] gf;
        logic [DIM_BITS-1:0] cf;
        assign gf        = grid_reg[(2-a)*DIM_BITS +: DIM_BITS];
        assign cf        = own_reg[(2-a)*DIM_BITS +: DIM_BITS];
        assign dim[a]    = {1'b0, gf} + 1'b1;
        assign own[a]    = (cf > gf) ? gf : cf;
        assign margin[a] = margin_reg[a];
    end

endmodule

// File: sv/hdc_alu.sv
// Shared arithmetic unit: one coordinate/margin by grid-size multiplier and
// the two-sided slab window compare. Depends on hdc_pkg (slab_flags_t).
module hdc_alu #(
    parameter int FRAC_BITS = 24,
    parameter int DIM_BITS  = 4
) (
    input  logic [FRAC_BITS+1:0]          mul_a,
    input  logic [DIM_BITS:0]             mul_b,
    output logic [FRAC_BITS+DIM_BITS+2:0] prod,
    input  logic [FRAC_BITS+DIM_BITS:0]   p,
    input  logic [FRAC_BITS+DIM_BITS+2:0] md,
    input  logic [DIM_BITS:0]             d,
    input  logic [DIM_BITS-1:0]           t,
    input  logic signed [1:0]             s,
    output hdc_pkg::slab_flags_t          flags
);

    localparam int MW = FRAC_BITS + DIM_BITS + 3;
    localparam int W  = FRAC_BITS + DIM_BITS + 5;

    logic signed [W-1:0] p_s;
    logic signed [W-1:0] md_s;
    logic signed [W-1:0] ds;
    logic signed [W-1:0] ts;
    logic signed [W-1:0] one_s;
    logic signed [W-1:0] lhs;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;

    assign prod = MW'(mul_a) * MW'(mul_b);

    // D*(f + s*S) against [t*S - m*D, (t+1)*S + m*D)
    always_comb
    begin
        p_s   = $signed(W'(p));
        md_s  = $signed(W'(md));
        ds    = $signed(W'(d)) <<< FRAC_BITS;
        ts    = $signed(W'(t)) <<< FRAC_BITS;
        one_s = $signed(W'(1)) <<< FRAC_BITS;
        if (s == 2'sb01)
            lhs = p_s + ds;
        else if (s == 2'sb11)
            lhs = p_s - ds;
        else
            lhs = p_s;
        lo = ts - md_s;
        hi = ts + one_s + md_s;
        flags.ge_lo = (lhs >= lo);
        flags.lt_hi = (lhs < hi);
    end

endmodule
